/* rtl/core/assert_macros.svh */
// Assertion helpers included by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* rtl/core/odas_pkg.sv */
package odas_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_OLDEST = 2'd2;

   // Status codes carried on rsp_tuser
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISS    = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int ADDR_W = 64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;    // capture request, clear result
      logic       idx_clear;   // slot index to zero
      logic       idx_inc;     // slot index plus one
      logic       rd_en;       // read memory
      logic       rd_next;     // read at index plus one, else at index
      logic       wr_en;       // write memory
      logic       wr_shift;    // write read data at index, else key at count
      logic       cnt_inc;
      logic       cnt_dec;
      logic       take;        // capture read data as removed address
      logic       set_status;
      logic [1:0] status_code;
      logic       rsp_load;    // move result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       full;
      logic       scan_done;   // index reached count
      logic       hit;         // read data equals key
      logic       shift_done;  // index plus one reached count
      logic       rsp_busy;    // output register holds an untaken result
   } stat_type;

endpackage

/* rtl/core/odas_datapath.sv */
`include "assert_macros.svh"

module odas_datapath #(
   parameter int ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  odas_pkg::cmd_type           cmd,
   output odas_pkg::stat_type          stat,
   input  logic [1:0]                  req_tuser,
   input  logic [odas_pkg::ADDR_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [1:0]                  rsp_tuser,
   output logic [odas_pkg::ADDR_W-1:0] rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [odas_pkg::ADDR_W-1:0] mem [ENTRIES];

   logic [odas_pkg::ADDR_W-1:0] key_ff, key_in;
   logic [1:0]                  op_ff, op_in;
   logic [CNT_W-1:0]            idx_ff, idx_in, idx_plus;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [odas_pkg::ADDR_W-1:0] rd_data_ff;
   logic [1:0]                  res_status_ff, res_status_in;
   logic [odas_pkg::ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [odas_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [IDX_W-1:0]            rd_addr, wr_addr;
   logic [odas_pkg::ADDR_W-1:0] wr_data;

   assign idx_plus = idx_ff + CNT_W'(1);

   // Capture the request
   assign key_in = cmd.load_req ? req_tdata : key_ff;
   assign op_in  = cmd.load_req ? req_tuser : op_ff;

   // Advance the slot index and the fill count
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Address memory: append at count or shift one slot down
   assign rd_addr = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_addr = cmd.wr_shift ? idx_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_shift ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Build the result
   always_comb begin
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      if (cmd.load_req) begin
         res_addr_in   = '0;
         res_status_in = odas_pkg::ST_MISS;
      end
      if (cmd.take) begin
         res_addr_in = rd_data_ff;
      end
      if (cmd.set_status) begin
         res_status_in = cmd.status_code;
      end
   end

   // Output register: load when free, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in   = res_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // Status to the controller
   assign stat.op         = op_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.full       = (count_ff == CNT_W'(ENTRIES));
   assign stat.scan_done  = (idx_ff == count_ff);
   assign stat.hit        = (rd_data_ff == key_ff);
   assign stat.shift_done = (idx_plus >= count_ff);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_addr_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(ENTRIES))
   `ASSERT_NEVER(a_append_full, clock, reset, cmd.cnt_inc && stat.full)
   `ASSERT_NEVER(a_pop_empty, clock, reset, cmd.cnt_dec && stat.count_zero)
   `ASSERT_CLK(a_no_overwrite, clock, reset,
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_tready))

endmodule

/* rtl/core/odas_ctrl.sv */
module odas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  odas_pkg::stat_type stat,
   output odas_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CMP = 3'd3;
   localparam logic [2:0] S_TAKE     = 3'd4;
   localparam logic [2:0] S_SHIFT_RD = 3'd5;
   localparam logic [2:0] S_SHIFT_WR = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Sequence one request through scan or take, shift and result
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req  = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               odas_pkg::OP_INSERT, odas_pkg::OP_REMOVE: begin
                  state_in = S_SCAN_RD;
               end
               odas_pkg::OP_OLDEST: begin
                  if (stat.count_zero) begin
                     state_in = S_RESP;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_TAKE;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = S_RESP;
               if (stat.op == odas_pkg::OP_INSERT) begin
                  cmd.set_status = 1'b1;
                  if (stat.full) begin
                     cmd.status_code = odas_pkg::ST_FULL;
                  end else begin
                     cmd.status_code = odas_pkg::ST_DONE;
                     cmd.wr_en       = 1'b1;
                     cmd.cnt_inc     = 1'b1;
                  end
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.hit) begin
               if (stat.op == odas_pkg::OP_INSERT) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = odas_pkg::ST_PRESENT;
                  state_in        = S_RESP;
               end else begin
                  cmd.take = 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               cmd.cnt_dec     = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status_code = odas_pkg::ST_DONE;
               state_in        = S_RESP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/ordered_dirty_address_set.sv */
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tuser: operation, tdata: address
// rsp       out        rsp_tvalid/rsp_tready   tuser: status, tdata: address_out
//
// One request at a time; addresses sit in a single-port memory, oldest first.
// Insert and named remove scan the memory slot by slot, a read then a compare;
// a removal then closes the gap by reading and rewriting each later slot one
// place down. Remove oldest reads slot zero and closes the gap the same way.
// Reset (synchronous, active high) empties the set at once; no clearing pass.
// The result waits in an output register; a stalled rsp holds the next result.
module ordered_dirty_address_set #(
   parameter int ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,   // [1:0] operation
   input  logic [odas_pkg::ADDR_W-1:0] req_tdata,   // [63:0] address
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [1:0]                  rsp_tuser,   // [1:0] status
   output logic [odas_pkg::ADDR_W-1:0] rsp_tdata    // [63:0] address_out
);

   odas_pkg::cmd_type  cmd;
   odas_pkg::stat_type stat;

   odas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   odas_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
